[rtl/core/crle_pkg.sv]
// Package with the item types and constants of the Catmull-Rom loop evaluator.
`timescale 1ns / 1ps

package crle_pkg;

  // Table geometry and field widths.
  localparam int MAX_POINTS = 64;
  localparam int PIDX_W     = 6;
  localparam int CNT_W      = 7;
  localparam int COORD_W    = 32;
  localparam int POINT_W    = 3 * COORD_W;
  localparam int POS_W      = 16;
  localparam int ADDR_W     = 3;

  // Reset value of the point count register.
  localparam logic [CNT_W-1:0] POINT_COUNT_RESET = 7'd4;

  // Item operations.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_POINT_COUNT = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_t;

  // Input item.
  typedef struct packed {
    logic                      op;
    logic [PIDX_W-1:0]         point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [POS_W-1:0]          loop_position;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] tangent_x;
    logic signed [COORD_W-1:0] tangent_y;
    logic signed [COORD_W-1:0] tangent_z;
  } out_item_t;

endpackage

[rtl/core/crle_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module crle_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; the read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/catmull_rom_loop_evaluator_unit.sv]
// Top level of the closed-loop Catmull-Rom spline evaluator.
`timescale 1ns / 1ps

// Seven-stage pipeline that takes one item per cycle while the result side
// keeps up. An evaluate item moves through the stage registers s1 to s6 into
// the output register, where it waits for out_ready. A write item gives no
// result. It updates the point table at the edge that moves it out of the
// first stage, always in item order, so an evaluate accepted after a write
// always sees the written point. The table is held in four copies of a
// 64 x 96 RAM so the four neighbors of a segment are read together. Stage by
// stage: segment and local parameter, neighbor indexes with t^2 and the
// table read, t^3, the basis weights, 24 products of 33 x 32 bits, the sums,
// and rounding with saturation. Stalls on the result side fill bubbles first,
// so the input stays ready until all seven stages hold items. The user must
// write point_count only while no item is in flight; the block itself does
// not enforce this.
module catmull_rom_loop_evaluator_unit
  import crle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int NS = 7;

  logic [CNT_W-1:0] point_count;
  logic [NS:1]      v;
  logic [NS+1:1]    en;

  // Configuration register.
  reg_idx_t reg_sel;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RESET;
    end else if (psel && penable && pwrite && reg_sel == REG_POINT_COUNT) begin
      point_count <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_POINT_COUNT: prdata = {{(32-CNT_W){1'b0}}, point_count};
      default:         prdata = '0;
    endcase
  end

  // Stage advance: a stage moves when it is empty or its successor moves.
  assign en[NS+1] = out_ready;
  generate
    for (genvar k = 1; k <= NS; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
  endgenerate
  assign in_ready = en[1];

  // Stage 1: clamp the count and split the position into segment and t.
  logic [CNT_W-1:0]   n_eff;
  logic [POS_W+CNT_W-1:0] g;
  logic               s1_op;
  logic [PIDX_W-1:0]  s1_idx;
  logic [POINT_W-1:0] s1_pt;
  logic [PIDX_W-1:0]  s1_seg;
  logic [POS_W-1:0]   s1_t;
  logic [CNT_W-1:0]   s1_n;

  always_comb begin
    if (point_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (point_count > CNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = point_count;
    end
    g = (POS_W+CNT_W)'(in_data.loop_position) * (POS_W+CNT_W)'(n_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[1] <= 1'b0;
    end else if (en[1]) begin
      v[1] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_op  <= in_data.op;
      s1_idx <= in_data.point_index;
      s1_pt  <= {in_data.coord_x, in_data.coord_y, in_data.coord_z};
      s1_seg <= g[POS_W+PIDX_W-1:POS_W];
      s1_t   <= g[POS_W-1:0];
      s1_n   <= n_eff;
    end
  end

  // Stage 2: neighbor indexes with wrap-around, t^2 and the table access.
  logic [PIDX_W-1:0]  ridx [4];
  logic [CNT_W-1:0]   seg_inc;
  logic [CNT_W-1:0]   nxt_inc;
  logic               tbl_we;
  logic [POINT_W-1:0] rd [4];
  logic [POS_W-1:0]   s2_t;
  logic [2*POS_W-1:0] s2_t2;

  always_comb begin
    ridx[1] = s1_seg;
    if (s1_seg == '0) begin
      ridx[0] = PIDX_W'(s1_n - CNT_W'(1));
    end else begin
      ridx[0] = s1_seg - PIDX_W'(1);
    end
    seg_inc = {1'b0, s1_seg} + CNT_W'(1);
    ridx[2] = (seg_inc == s1_n) ? '0 : seg_inc[PIDX_W-1:0];
    nxt_inc = {1'b0, ridx[2]} + CNT_W'(1);
    ridx[3] = (nxt_inc == s1_n) ? '0 : nxt_inc[PIDX_W-1:0];
  end

  assign tbl_we = v[1] && en[2] && s1_op == OP_WRITE &&
                  {1'b0, s1_idx} < CNT_W'(MAX_POINTS);

  generate
    for (genvar k = 0; k < 4; k++) begin : g_tbl
      crle_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
      ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (s1_idx),
        .wdata (s1_pt),
        .re    (en[2]),
        .raddr (ridx[k]),
        .rdata (rd[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v[2] <= 1'b0;
    end else if (en[2]) begin
      v[2] <= v[1] && s1_op == OP_EVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_t  <= s1_t;
      s2_t2 <= (2*POS_W)'(s1_t) * (2*POS_W)'(s1_t);
    end
  end

  // Stage 3: t^3, with the four points taken from the RAM outputs.
  logic [POS_W-1:0]   s3_t;
  logic [2*POS_W-1:0] s3_t2;
  logic [3*POS_W-1:0] s3_t3;
  logic [POINT_W-1:0] s3_p [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[3] <= 1'b0;
    end else if (en[3]) begin
      v[3] <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_t  <= s2_t;
      s3_t2 <= s2_t2;
      s3_t3 <= (3*POS_W)'(s2_t2) * (3*POS_W)'(s2_t);
      for (int k = 0; k < 4; k++) begin
        s3_p[k] <= rd[k];
      end
    end
  end

  // Stage 4: basis weights, point weights in Q.30 and tangent weights in Q.28.
  localparam int WX = 56;
  localparam int WW = 33;
  logic signed [WX-1:0] t1x, t2x, t3x;
  logic signed [WX-1:0] wx [4];
  logic signed [WX-1:0] dx [4];
  logic signed [WX-1:0] wr [4];
  logic signed [WX-1:0] dr [4];
  logic signed [WW-1:0] s4_w [4];
  logic signed [WW-1:0] s4_d [4];
  logic [POINT_W-1:0]   s4_p [4];

  always_comb begin
    t1x = signed'(WX'(s3_t));
    t2x = signed'(WX'(s3_t2));
    t3x = signed'(WX'(s3_t3));
    wx[0] = -t3x + (t2x <<< 17) - (t1x <<< 32);
    wx[1] = 3 * t3x - ((5 * t2x) <<< 16) + (WX'(1) <<< 49);
    wx[2] = -3 * t3x + (t2x <<< 18) + (t1x <<< 32);
    wx[3] = t3x - (t2x <<< 16);
    dx[0] = -3 * t2x + (t1x <<< 18) - (WX'(1) <<< 32);
    dx[1] = 9 * t2x - ((5 * t1x) <<< 17);
    dx[2] = -9 * t2x + (t1x <<< 19) + (WX'(1) <<< 32);
    dx[3] = 3 * t2x - (t1x <<< 17);
    for (int k = 0; k < 4; k++) begin
      wr[k] = (wx[k] + (WX'(1) <<< 18)) >>> 19;
      dr[k] = (dx[k] + (WX'(1) <<< 4)) >>> 5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[4] <= 1'b0;
    end else if (en[4]) begin
      v[4] <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 4; k++) begin
        s4_w[k] <= wr[k][WW-1:0];
        s4_d[k] <= dr[k][WW-1:0];
        s4_p[k] <= s3_p[k];
      end
    end
  end

  // Stage 5: one product per weight, neighbor and coordinate.
  localparam int PW = WW + COORD_W;
  logic signed [PW-1:0] s5_pp [3][4];
  logic signed [PW-1:0] s5_dp [3][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[5] <= 1'b0;
    end else if (en[5]) begin
      v[5] <= v[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          s5_pp[c][k] <= PW'(s4_w[k]) *
                         PW'(signed'(s4_p[k][POINT_W-1-c*COORD_W -: COORD_W]));
          s5_dp[c][k] <= PW'(s4_d[k]) *
                         PW'(signed'(s4_p[k][POINT_W-1-c*COORD_W -: COORD_W]));
        end
      end
    end
  end

  // Stage 6: sum the four weighted neighbors of each coordinate.
  localparam int SW = PW + 2;
  logic signed [SW-1:0] s6_ps [3];
  logic signed [SW-1:0] s6_ds [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[6] <= 1'b0;
    end else if (en[6]) begin
      v[6] <= v[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int c = 0; c < 3; c++) begin
        s6_ps[c] <= SW'(s5_pp[c][0]) + SW'(s5_pp[c][1]) +
                    SW'(s5_pp[c][2]) + SW'(s5_pp[c][3]);
        s6_ds[c] <= SW'(s5_dp[c][0]) + SW'(s5_dp[c][1]) +
                    SW'(s5_dp[c][2]) + SW'(s5_dp[c][3]);
      end
    end
  end

  // Stage 7: round to Q16.16 and saturate into the output register.
  logic signed [SW-1:0] pr [3];
  logic signed [SW-1:0] dq [3];
  logic [COORD_W-1:0]   pos_sat [3];
  logic [COORD_W-1:0]   tan_sat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pr[c] = (s6_ps[c] + (SW'(1) <<< 29)) >>> 30;
      dq[c] = (s6_ds[c] + (SW'(1) <<< 27)) >>> 28;
      if (pr[c] > SW'(32'sh7FFF_FFFF)) begin
        pos_sat[c] = 32'h7FFF_FFFF;
      end else if (pr[c] < -(SW'(1) <<< 31)) begin
        pos_sat[c] = 32'h8000_0000;
      end else begin
        pos_sat[c] = pr[c][COORD_W-1:0];
      end
      if (dq[c] > SW'(32'sh7FFF_FFFF)) begin
        tan_sat[c] = 32'h7FFF_FFFF;
      end else if (dq[c] < -(SW'(1) <<< 31)) begin
        tan_sat[c] = 32'h8000_0000;
      end else begin
        tan_sat[c] = dq[c][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[7] <= 1'b0;
    end else if (en[7]) begin
      v[7] <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_data.pos_x     <= pos_sat[0];
      out_data.pos_y     <= pos_sat[1];
      out_data.pos_z     <= pos_sat[2];
      out_data.tangent_x <= tan_sat[0];
      out_data.tangent_y <= tan_sat[1];
      out_data.tangent_z <= tan_sat[2];
    end
  end

  assign out_valid = v[NS];

`ifndef SYNTHESIS
  // An empty first stage always takes an item.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v[1] |-> in_ready)
    else $error("first stage empty but input not ready");

  // A write item never enters the evaluation stages.
  a_write_drops: assert property (@(posedge clk) disable iff (rst)
    (v[1] && en[2] && s1_op == OP_WRITE) |=> !v[2])
    else $error("write item entered evaluation stages");

  // The effective count stays within the table.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (n_eff != '0) && (n_eff <= CNT_W'(MAX_POINTS)))
    else $error("effective point count out of range");

  // Neighbor indexes stay below the loop length.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (v[1] && s1_op == OP_EVAL) |->
      ({1'b0, ridx[0]} < s1_n) && ({1'b0, ridx[3]} < s1_n))
    else $error("neighbor index beyond loop");
`endif

endmodule

[tb/testbench.sv]
// Testbench for the Catmull-Rom loop evaluator, checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import crle_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Predictor state: the control point table and the count register.
  longint pt_table [MAX_POINTS][3];
  logic [CNT_W-1:0] pred_count;
  out_item_t curve_queue[$];

  int sender_idle_pct;
  int receiver_idle_pct;
  int hold_req;
  int hold_seen;
  int hold_cnt;
  int errors;
  int cycles;

  catmull_rom_loop_evaluator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Round to nearest with halves toward +inf, by an arithmetic shift.
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > longint'(32'sh7fffffff)) v = longint'(32'sh7fffffff);
    if (v < -longint'(64'h80000000)) v = -longint'(64'h80000000);
    return v[31:0];
  endfunction

  // Curve point and tangent for one loop position, from the predicted table.
  function automatic out_item_t eval_curve(logic [POS_W-1:0] loop_pos);
    longint n, g, seg, t1, t2, t3, ps, ds, v;
    longint w[4];
    longint d[4];
    int idx[4];
    logic [COORD_W-1:0] res[6];
    out_item_t r;
    n = pred_count;
    if (n == 0) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    g = longint'(loop_pos) * n;
    seg = g >>> 16;
    t1 = g & 64'hffff;
    t2 = t1 * t1;
    t3 = t2 * t1;
    idx[0] = int'((seg + n - 1) % n);
    for (int k = 1; k < 4; k++) idx[k] = int'((idx[k-1] + 1) % n);
    w[0] = -t3 + t2 * (longint'(1) << 17) - t1 * (longint'(1) << 32);
    w[1] = 3 * t3 - 5 * t2 * (longint'(1) << 16) + (longint'(1) << 49);
    w[2] = -3 * t3 + t2 * (longint'(1) << 18) + t1 * (longint'(1) << 32);
    w[3] = t3 - t2 * (longint'(1) << 16);
    d[0] = -3 * t2 + t1 * (longint'(1) << 18) - (longint'(1) << 32);
    d[1] = 9 * t2 - 5 * t1 * (longint'(1) << 17);
    d[2] = -9 * t2 + t1 * (longint'(1) << 19) + (longint'(1) << 32);
    d[3] = 3 * t2 - t1 * (longint'(1) << 17);
    for (int k = 0; k < 4; k++) begin
      w[k] = round_shift(w[k], 19);
      d[k] = round_shift(d[k], 5);
    end
    for (int c = 0; c < 3; c++) begin
      ps = 0;
      ds = 0;
      for (int k = 0; k < 4; k++) begin
        v = pt_table[idx[k]][c];
        ps += w[k] * v;
        ds += d[k] * v;
      end
      res[c] = sat32(round_shift(ps, 30));
      res[3 + c] = sat32(round_shift(ds, 28));
    end
    r.pos_x = res[0];
    r.pos_y = res[1];
    r.pos_z = res[2];
    r.tangent_x = res[3];
    r.tangent_y = res[4];
    r.tangent_z = res[5];
    return r;
  endfunction

  // Update the predictor for one accepted item.
  task automatic predict_item(in_item_t it);
    if (it.op == OP_WRITE) begin
      pt_table[it.point_index][0] = longint'(it.coord_x);
      pt_table[it.point_index][1] = longint'(it.coord_y);
      pt_table[it.point_index][2] = longint'(it.coord_z);
    end else begin
      curve_queue.insert(curve_queue.size(), eval_curve(it.loop_position));
    end
  endtask

  // Offer one item, with an optional gap first, and wait for acceptance.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(it);
  endtask

  // Let the pipeline empty, then write a register over the APB port.
  task automatic write_point_count(logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (curve_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * REG_POINT_COUNT);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pred_count = value;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_write(int slot, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z);
    in_item_t it;
    it.op = OP_WRITE;
    it.point_index = slot[PIDX_W-1:0];
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    it.loop_position = POS_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_eval(logic [POS_W-1:0] loop_pos);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    it.op = OP_EVAL;
    it.loop_position = loop_pos;
    return it;
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    if ($urandom_range(99) < 35)
      return make_write($urandom_range(MAX_POINTS - 1), rand_coord(), rand_coord(), rand_coord());
    return make_eval(rand_pos());
  endfunction

  // Result side: random stalls, a long hold-off on request, and the check.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (curve_queue.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, out_data);
        errors++;
      end else begin
        want = curve_queue.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (want[192 - 32 * (k + 1) +: 32] !== out_data[192 - 32 * (k + 1) +: 32]) begin
            $display("%0t: field %0d mismatch, expected %h, actual %h", $time, k,
                     want[192 - 32 * (k + 1) +: 32], out_data[192 - 32 * (k + 1) +: 32]);
            errors++;
          end
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Extremes of the coordinates and positions with small point counts.
  task automatic test_directed();
    send_item(make_write(0, 32'h7fffffff, 32'h80000000, 32'h00000000));
    send_item(make_write(1, 32'h80000000, 32'h7fffffff, 32'h00010000));
    send_item(make_write(2, 32'h7fffffff, 32'h7fffffff, 32'hffff0000));
    send_item(make_write(3, 32'h80000000, 32'h80000000, 32'h12345678));
    send_item(make_eval(16'h0000));
    send_item(make_eval(16'hffff));
    send_item(make_eval(16'h8000));
    send_item(make_eval(16'h2aaa));
    // One and two points: the neighbors repeat.
    write_point_count(7'd1);
    send_item(make_eval(16'h0000));
    send_item(make_eval(16'h7fff));
    write_point_count(7'd2);
    send_item(make_eval(16'h8000));
    send_item(make_eval(16'hc123));
    // A count of zero acts as one.
    write_point_count(7'd0);
    send_item(make_eval(16'h4000));
  endtask

  // Store every slot so that no evaluation reads an unwritten point.
  task automatic test_fill_table();
    for (int s = 0; s < MAX_POINTS; s++)
      send_item(make_write(s, rand_coord(), rand_coord(), rand_coord()));
  endtask

  task automatic test_random(logic [CNT_W-1:0] count, int snd_pct, int rcv_pct, int n_items);
    write_point_count(count);
    sender_idle_pct = snd_pct;
    receiver_idle_pct = rcv_pct;
    for (int i = 0; i < n_items; i++) send_item(rand_item());
  endtask

  // Hold the result side off long enough for the input to stall.
  task automatic test_backpressure();
    write_point_count(7'd5);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_req++;
    for (int i = 0; i < 60; i++) send_item(make_eval(rand_pos()));
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cycles = 0;
    errors = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_cnt = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    pred_count = POINT_COUNT_RESET;
    for (int s = 0; s < MAX_POINTS; s++)
      for (int c = 0; c < 3; c++) pt_table[s][c] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_table();
    test_random(7'd127, 23, 80, 400);
    test_random(7'd3, 80, 23, 400);
    test_random(7'd64, 0, 0, 400);
    test_random(7'($urandom_range(64, 1)), 23, 80, 150);
    test_random(7'd65, 80, 23, 150);
    test_backpressure();

    // Drain the pipeline and report.
    in_valid <= 1'b0;
    @(posedge clk);
    while (curve_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
